// ===== rtl/core/escape_time_fractal_iteration_macros.svh =====
// Assertion macros for the escape-time fractal iteration block.
`ifndef ESCAPE_TIME_FRACTAL_ITERATION_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATION_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define EFI_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("efi: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define EFI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("efi: next-cycle check failed");

`endif

// ===== rtl/core/efi_pkg.sv =====
// Shared types and constants for the escape-time fractal iteration block.
package efi_pkg;

    localparam int FRAC_BITS_DEFAULT = 24;

    localparam int COORD_W = 32;
    localparam int COUNT_W = 16;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd256;

    typedef enum logic [1:0] {
        REG_SEED_REAL = 2'd0,
        REG_SEED_IMAG = 2'd1,
        REG_MAX_ITER  = 2'd2
    } reg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQX  = 6'b000010,
        ST_SQY  = 6'b000100,
        ST_XY   = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

// ===== rtl/core/escape_time_fractal_iteration.sv =====
// Escape-time fractal iteration top level with APB configuration and stream ports.
//
// Each accepted pixel is iterated as z = z*z + pixel from the configured seed, in
// signed 32-bit fixed point, and one iteration count is returned per pixel. A single
// 32x32 signed multiplier is shared by the three products of an iteration, which
// steps through states SQX, SQY, XY and UPD. A pixel that escapes after its
// count-th test runs count+1 iterations; one that survives runs max_iterations.
// The result is then offered in state OUT (straight from IDLE when max_iterations
// is 0), and the input is not ready until that result transfer.
`include "escape_time_fractal_iteration_macros.svh"

module escape_time_fractal_iteration #(
    parameter int FRAC_BITS = efi_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efi_pkg::ADDR_W-1:0]  paddr,
    input  logic [efi_pkg::DATA_W-1:0]  pwdata,
    output logic [efi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // pixel_real[31:0], pixel_imag[63:32]

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata    // iteration_count[15:0]
);

    import efi_pkg::*;

    localparam logic signed [COORD_W-1:0] LIMIT = COORD_W'(1) <<< (FRAC_BITS + 2);

    state_t state_reg, state_next;

    logic [COORD_W-1:0] seed_real_reg, seed_real_next;
    logic [COORD_W-1:0] seed_imag_reg, seed_imag_next;
    logic [COUNT_W-1:0] max_iter_reg, max_iter_next;

    logic [COORD_W-1:0] cr_reg, cr_next;
    logic [COORD_W-1:0] ci_reg, ci_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [COORD_W-1:0] x2_reg, x2_next;
    logic [COORD_W-1:0] y2_reg, y2_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic signed [COORD_W-1:0] mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic [COORD_W-1:0]        prod_fx;
    logic [COORD_W-1:0]        sq_sum;
    logic                      alive;
    logic [COUNT_W:0]          count_inc;
    logic                      cfg_wr;
    reg_idx_t                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb begin
        case (cfg_idx)
            REG_SEED_REAL: prdata = seed_real_reg;
            REG_SEED_IMAG: prdata = seed_imag_reg;
            REG_MAX_ITER:  prdata = {{(DATA_W-COUNT_W){1'b0}}, max_iter_reg};
            default:       prdata = '0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = count_reg;

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_SQX: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            ST_SQY: begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default: begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_fx   = prod_reg[FRAC_BITS +: COORD_W];
    assign sq_sum    = x2_reg + y2_reg;
    assign alive     = $signed(sq_sum) < LIMIT;
    assign count_inc = {1'b0, count_reg} + (COUNT_W+1)'(1);

    always_comb begin
        state_next     = state_reg;
        seed_real_next = seed_real_reg;
        seed_imag_next = seed_imag_reg;
        max_iter_next  = max_iter_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        count_next     = count_reg;

        if (cfg_wr) begin
            case (cfg_idx)
                REG_SEED_REAL: seed_real_next = pwdata;
                REG_SEED_IMAG: seed_imag_next = pwdata;
                REG_MAX_ITER:  max_iter_next  = pwdata[COUNT_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cr_next    = s_tdata[COORD_W-1:0];
                    ci_next    = s_tdata[2*COORD_W-1:COORD_W];
                    x_next     = seed_real_reg;
                    y_next     = seed_imag_reg;
                    count_next = '0;
                    state_next = (max_iter_reg == '0) ? ST_OUT : ST_SQX;
                end
            end
            ST_SQX: state_next = ST_SQY;
            ST_SQY: begin
                x2_next    = prod_fx;
                state_next = ST_XY;
            end
            ST_XY: begin
                y2_next    = prod_fx;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                y_next = {prod_fx[COORD_W-2:0], 1'b0} + ci_reg;
                x_next = x2_reg - y2_reg + cr_reg;
                if (!alive) begin
                    state_next = ST_OUT;
                end else begin
                    count_next = count_inc[COUNT_W-1:0];
                    state_next = (count_inc == {1'b0, max_iter_reg}) ? ST_OUT : ST_SQX;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seed_real_reg <= '0;
            seed_imag_reg <= '0;
            max_iter_reg  <= MAX_ITER_RESET;
        end else begin
            state_reg     <= state_next;
            seed_real_reg <= seed_real_next;
            seed_imag_reg <= seed_imag_next;
            max_iter_reg  <= max_iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        prod_reg  <= prod_next;
        count_reg <= count_next;
    end

    `EFI_ASSERT_SAME(a_ready_excl_valid, aclk, aresetn, s_tready, !m_tvalid)
    `EFI_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `EFI_ASSERT_NEXT(a_ready_after_out, aclk, aresetn, m_tvalid && m_tready, s_tready)
    `EFI_ASSERT_SAME(a_count_bound, aclk, aresetn, !s_tready, count_reg <= max_iter_reg)

endmodule

// ===== tb/escape_time_fractal_iteration_tb.sv =====
// Self-checking testbench for the escape-time fractal iteration block: directed table, then random pixels.
module escape_time_fractal_iteration_tb;
    import efi_pkg::*;

    localparam int FRAC_BITS      = FRAC_BITS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 1_000_000;
    localparam int MAX_REPORTS    = 10;
    localparam int N_PHASES       = 12;
    localparam int PHASE_ITEMS    = 120;
    localparam int N_DIRECTED     = 31;

    localparam logic signed [31:0] ESCAPE_LIMIT = 32'sd4 <<< FRAC_BITS;

    localparam logic [ADDR_W-1:0] ADDR_SEED_RE  = {REG_SEED_REAL, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SEED_IM  = {REG_SEED_IMAG, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_MAX_ITER = {REG_MAX_ITER, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 4'd12;

    typedef enum logic { ROW_WRITE, ROW_PIXEL } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       re;     // write data for ROW_WRITE
        logic [31:0]       im;
        logic              fixed;  // count typed in below
        logic [15:0]       count;
    } row_t;

    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_PIXEL, 4'd0,          32'h0000_0000, 32'h0000_0000, 1'b1, 16'd256},
        '{ROW_PIXEL, 4'd0,          32'h0200_0000, 32'h0000_0000, 1'b1, 16'd1},
        '{ROW_PIXEL, 4'd0,          32'hFE00_0000, 32'h0000_0000, 1'b1, 16'd1},
        '{ROW_PIXEL, 4'd0,          32'hFF00_0000, 32'h0000_0000, 1'b1, 16'd256},
        '{ROW_PIXEL, 4'd0,          32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h8000_0000, 32'h8000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h0000_0000, 32'h0100_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h0040_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h0042_8F5C, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_WRITE, ADDR_MAX_ITER, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'd0},
        '{ROW_WRITE, ADDR_MAX_ITER, 32'h0000_0001, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h0000_0000, 32'h0000_0000, 1'b1, 16'd1},
        '{ROW_PIXEL, 4'd0,          32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd1},
        '{ROW_WRITE, ADDR_SEED_RE,  32'h8000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_WRITE, ADDR_SEED_IM,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_WRITE, ADDR_MAX_ITER, 32'h0000_0010, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h1234_5678, 32'hEDCB_A987, 1'b0, 16'd0},
        '{ROW_WRITE, ADDR_SEED_RE,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_WRITE, ADDR_SEED_IM,  32'h8000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 16'd0},
        '{ROW_WRITE, ADDR_SEED_RE,  32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_WRITE, ADDR_SEED_IM,  32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_WRITE, ADDR_MAX_ITER, 32'h0000_FFFF, 32'h0000_0000, 1'b0, 16'd0},
        '{ROW_PIXEL, 4'd0,          32'h0400_0000, 32'h0000_0000, 1'b1, 16'd1},
        '{ROW_PIXEL, 4'd0,          32'h0000_0000, 32'h0000_0000, 1'b1, 16'd65535},
        '{ROW_WRITE, ADDR_UNMAPPED, 32'hDEAD_BEEF, 32'h0000_0000, 1'b0, 16'd0}
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata = '0;   // pixel_real[31:0], pixel_imag[63:32]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;        // iteration_count[15:0]

    logic [31:0] seed_re = '0;
    logic [31:0] seed_im = '0;
    logic [15:0] iter_bound = MAX_ITER_RESET;
    logic [15:0] pending_counts [$];
    int          n_errors = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b0;

    escape_time_fractal_iteration #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic signed [31:0] fixed_mul(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p[FRAC_BITS+31:FRAC_BITS];
    endfunction

    function automatic logic [15:0] escape_count(input logic [31:0] c_re,
                                                 input logic [31:0] c_im);
        logic signed [31:0] x, y, xx, yy, xy;
        logic [15:0]        n;
        x = seed_re;
        y = seed_im;
        n = '0;
        for (int i = 0; i < int'(iter_bound); i++) begin
            xx = fixed_mul(x, x);
            yy = fixed_mul(y, y);
            xy = fixed_mul(x, y);
            // escape test on the wrapped sum, signed
            if (!(32'(xx + yy) < ESCAPE_LIMIT))
                break;
            y = (xy <<< 1) + c_im;
            x = xx - yy + c_re;
            n++;
        end
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    task automatic report(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Starts and ends just after a falling edge; waits a further falling edge with psel low before returning.
    task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        rdata = prdata;
        if (write) begin
            case (addr)
                ADDR_SEED_RE:  seed_re = wdata;
                ADDR_SEED_IM:  seed_im = wdata;
                ADDR_MAX_ITER: iter_bound = wdata[15:0];
                default: ;
            endcase
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        reg_idx_t    regs [3];
        logic [31:0] got, want;
        regs = '{REG_SEED_REAL, REG_SEED_IMAG, REG_MAX_ITER};
        apb_access(1'b1, addr, value, got);
        foreach (regs[k]) begin
            apb_access(1'b0, {regs[k], 2'b00}, '0, got);
            case (regs[k])
                REG_SEED_REAL: want = seed_re;
                REG_SEED_IMAG: want = seed_im;
                default: begin
                    want = {16'd0, iter_bound};
                    got[31:16] = '0;
                end
            endcase
            if (got !== want)
                report($sformatf("register %0d readback: expected %h, got %h",
                                 regs[k], want, got));
        end
    endtask

    // Starts and ends just after a falling edge.
    task automatic send_pixel(input logic [31:0] re, input logic [31:0] im,
                              input logic fixed, input logic [15:0] count);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_counts.push_back(fixed ? count : escape_count(re, im));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_counts.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin : result_check
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                report($sformatf("unexpected result transfer: count %0d", m_tdata));
            end else begin
                want = pending_counts.pop_front();
                if (m_tdata !== want)
                    report($sformatf("iteration_count: expected %0d, got %0d", want, m_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [15:0] bound;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        idle_on = 1'b1;
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                drain();
                write_reg(DIRECTED[i].addr, DIRECTED[i].re);
            end else begin
                send_pixel(DIRECTED[i].re, DIRECTED[i].im, DIRECTED[i].fixed,
                           DIRECTED[i].count);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            idle_on = (ph % 3 != 2);
            case (ph)
                0:       bound = 16'd1;
                5:       bound = 16'($urandom_range(200, 320));
                default: bound = 16'($urandom_range(2, 48));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(ADDR_SEED_RE, '0);
                3:       write_reg(ADDR_SEED_RE, $urandom());
                default: write_reg(ADDR_SEED_RE, rand_coord());
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(ADDR_SEED_IM, '0);
                3:       write_reg(ADDR_SEED_IM, $urandom());
                default: write_reg(ADDR_SEED_IM, rand_coord());
            endcase
            write_reg(ADDR_MAX_ITER, {16'd0, bound});
            repeat (PHASE_ITEMS)
                send_pixel(rand_coord(), rand_coord(), 1'b0, '0);
        end

        drain();
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/efi_pkg.sv
rtl/core/escape_time_fractal_iteration.sv
tb/escape_time_fractal_iteration_tb.sv
